[rtl/intlex_pkg.sv]
package intlex_pkg;

	localparam int VALUE_BITS = 32;
	// decimal product dec*10+d needs four extra bits over the 31-bit accumulator
	localparam int DEC_W = VALUE_BITS + 3;
	localparam logic [DEC_W-1:0] DEC_LIMIT = {{4{1'b0}}, {(VALUE_BITS-1){1'b1}}};

	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_SAT = 4'd12;
	localparam logic [CNT_W-1:0] OCT_MAX_DIGITS = 4'd11;
	localparam logic [CNT_W-1:0] HEX_MAX_DIGITS = 4'd8;
	localparam logic [CNT_W-1:0] DEC_MAX_DIGITS = 4'd10;

	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_THREE = 8'd51;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_LO_A = 8'd97;
	localparam logic [7:0] CH_LO_F = 8'd102;
	localparam logic [7:0] CH_UP_A = 8'd65;
	localparam logic [7:0] CH_UP_F = 8'd70;
	localparam logic [7:0] CH_LO_H = 8'd104;
	localparam logic [7:0] CH_UP_H = 8'd72;
	localparam logic [7:0] CH_LO_B = 8'd98;
	localparam logic [7:0] CH_UP_B = 8'd66;

	// base codes double as the kind codes of a token
	localparam logic [1:0] KIND_OCT = 2'd0;
	localparam logic [1:0] KIND_DEC = 2'd1;
	localparam logic [1:0] KIND_HEX = 2'd2;

	localparam logic [1:0] SIGN_NONE = 2'd0;
	localparam logic [1:0] SIGN_PLUS = 2'd1;
	localparam logic [1:0] SIGN_MINUS = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_BAD_SUFFIX = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic       is_dec;
		logic       is_hex;
		logic       is_zero;
		logic       is_sign;
		logic       is_minus;
		logic       is_h;
		logic       is_b;
		logic [3:0] hv;
	} char_class_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [1:0]            kind;
		logic [2:0]            status;
	} token_t;

endpackage

[rtl/intlex_class.sv]
module intlex_class (
	input  logic [7:0]                 char_code,
	output intlex_pkg::char_class_t    cls
);
	import intlex_pkg::*;

	logic lower_af;
	logic upper_af;

	assign lower_af = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
	assign upper_af = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);

	always_comb begin
		cls.is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		cls.is_hex   = cls.is_dec || lower_af || upper_af;
		cls.is_zero  = (char_code == CH_ZERO);
		cls.is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		cls.is_minus = (char_code == CH_MINUS);
		cls.is_h     = (char_code == CH_LO_H) || (char_code == CH_UP_H);
		cls.is_b     = (char_code == CH_LO_B) || (char_code == CH_UP_B);
		// letters a-f and A-F both sit at low nibble 1..6
		cls.hv       = cls.is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
	end

endmodule

[rtl/intlex_core.sv]
module intlex_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            char_code,
	input  logic                  is_last,
	output intlex_pkg::token_t    token
);
	import intlex_pkg::*;

	char_class_t cls;

	logic                  at_start_q;
	logic [1:0]            sign_q;
	logic [7:0]            first_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [1:0]            base_q;
	logic [2:0]            err_q;
	logic [VALUE_BITS-1:0] oct_q;
	logic [VALUE_BITS-1:0] hex_q;
	logic [VALUE_BITS-2:0] dec_q;
	logic                  over_q;

	logic                  at_start_n;
	logic [1:0]            sign_n;
	logic [7:0]            first_n;
	logic [CNT_W-1:0]      cnt_n;
	logic [1:0]            base_n;
	logic [2:0]            err_n;
	logic [VALUE_BITS-1:0] oct_n;
	logic [VALUE_BITS-1:0] hex_n;
	logic [VALUE_BITS-2:0] dec_n;
	logic                  over_n;

	// state after taking the current char as a significant digit
	logic [7:0]            tk_first;
	logic [CNT_W-1:0]      tk_cnt;
	logic [VALUE_BITS-1:0] tk_oct;
	logic [VALUE_BITS-1:0] tk_hex;
	logic [VALUE_BITS-2:0] tk_dec;
	logic                  tk_over;
	logic [DEC_W-1:0]      dec_t;
	logic [VALUE_BITS-1:0] dec_ext;
	logic [2:0]            st;

	intlex_class u_class (
		.char_code (char_code),
		.cls       (cls)
	);

	always_comb begin
		tk_first = (first_q == 8'd0) ? char_code : first_q;
		tk_cnt   = (cnt_q < CNT_SAT) ? cnt_q + 4'd1 : cnt_q;
		tk_hex   = {hex_q[VALUE_BITS-5:0], cls.hv};
		tk_oct   = oct_q;
		tk_dec   = dec_q;
		tk_over  = over_q;
		dec_t    = ({4'b0, dec_q} << 3) + ({4'b0, dec_q} << 1) + DEC_W'(cls.hv);
		if (cls.is_dec) begin
			tk_oct = (oct_q << 3) + VALUE_BITS'(cls.hv);
			if (!over_q) begin
				if (dec_t > DEC_LIMIT)
					tk_over = 1'b1;
				else
					tk_dec = dec_t[VALUE_BITS-2:0];
			end
		end
	end

	always_comb begin
		at_start_n = at_start_q;
		sign_n     = sign_q;
		first_n    = first_q;
		cnt_n      = cnt_q;
		base_n     = base_q;
		err_n      = err_q;
		oct_n      = oct_q;
		hex_n      = hex_q;
		dec_n      = dec_q;
		over_n     = over_q;

		if (at_start_q && cls.is_sign) begin
			at_start_n = 1'b0;
			sign_n     = cls.is_minus ? SIGN_MINUS : SIGN_PLUS;
			if (is_last)
				err_n = ST_BAD_SUFFIX;
		end else if (!is_last) begin
			at_start_n = 1'b0;
			if (err_q == ST_OK) begin
				if (cls.is_zero && cnt_q == '0) begin
					// leading zero, not significant
				end else if (cls.is_hex) begin
					first_n = tk_first;
					cnt_n   = tk_cnt;
					oct_n   = tk_oct;
					hex_n   = tk_hex;
					dec_n   = tk_dec;
					over_n  = tk_over;
					if (!cls.is_dec)
						base_n = KIND_HEX;
					else if (cls.hv[3] && base_q == KIND_OCT)
						base_n = KIND_DEC;
				end else begin
					err_n = ST_INVALID;
				end
			end
		end else if (err_q == ST_OK) begin
			// suffix character picks the kind
			if (cls.is_h) begin
				base_n = KIND_HEX;
			end else if (cls.is_b) begin
				if (base_q != KIND_OCT)
					err_n = ST_BAD_SUFFIX;
			end else if (cls.is_dec) begin
				if (base_q == KIND_HEX) begin
					err_n = ST_BAD_SUFFIX;
				end else begin
					base_n = KIND_DEC;
					if (!(cls.is_zero && cnt_q == '0)) begin
						first_n = tk_first;
						cnt_n   = tk_cnt;
						oct_n   = tk_oct;
						hex_n   = tk_hex;
						dec_n   = tk_dec;
						over_n  = tk_over;
					end
				end
			end else begin
				err_n = ST_BAD_SUFFIX;
			end
		end
	end

	// token from the state as it stands after the last char
	always_comb begin
		st          = err_n;
		token.value = '0;
		dec_ext     = {1'b0, dec_n};
		if (st == ST_OK && sign_n != SIGN_NONE && base_n != KIND_DEC)
			st = ST_SIGN;
		if (st == ST_OK) begin
			case (base_n)
				KIND_OCT: begin
					if (cnt_n > OCT_MAX_DIGITS ||
						(cnt_n == OCT_MAX_DIGITS && first_n > CH_THREE))
						st = ST_OVERFLOW;
					token.value = oct_n;
				end
				KIND_HEX: begin
					if (cnt_n > HEX_MAX_DIGITS)
						st = ST_OVERFLOW;
					token.value = hex_n;
				end
				default: begin
					if (over_n || cnt_n > DEC_MAX_DIGITS)
						st = ST_OVERFLOW;
					token.value = (sign_n == SIGN_MINUS) ? ('0 - dec_ext) : dec_ext;
				end
			endcase
		end
		if (st != ST_OK)
			token.value = '0;
		token.status = st;
		if (st == ST_OK || st == ST_SIGN || st == ST_OVERFLOW) begin
			case (base_n)
				KIND_HEX: token.kind = KIND_HEX;
				KIND_DEC: token.kind = KIND_DEC;
				default:  token.kind = KIND_OCT;
			endcase
		end else begin
			token.kind = KIND_OCT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			sign_q     <= SIGN_NONE;
			first_q    <= '0;
			cnt_q      <= '0;
			base_q     <= KIND_OCT;
			err_q      <= ST_OK;
			oct_q      <= '0;
			hex_q      <= '0;
			dec_q      <= '0;
			over_q     <= 1'b0;
		end else if (step) begin
			if (is_last) begin
				// literal closed, back to the start state
				at_start_q <= 1'b1;
				sign_q     <= SIGN_NONE;
				first_q    <= '0;
				cnt_q      <= '0;
				base_q     <= KIND_OCT;
				err_q      <= ST_OK;
				oct_q      <= '0;
				hex_q      <= '0;
				dec_q      <= '0;
				over_q     <= 1'b0;
			end else begin
				at_start_q <= at_start_n;
				sign_q     <= sign_n;
				first_q    <= first_n;
				cnt_q      <= cnt_n;
				base_q     <= base_n;
				err_q      <= err_n;
				oct_q      <= oct_n;
				hex_q      <= hex_n;
				dec_q      <= dec_n;
				over_q     <= over_n;
			end
		end
	end

endmodule

[rtl/integer_literal_lexer.sv]
// Integer literal lexer. Characters of one literal arrive one per input beat, the
// last one flagged with s_tlast; that beat yields one token (value, status, kind),
// all other beats yield none. A beat is taken every cycle unless held up as below:
// it sits in the input register, then the lexer state updates in one pass, and a
// token lands in the output register as its last character leaves the input
// register. Only a token still waiting in the output register holds up the next
// last-character beat; other characters keep flowing.
module integer_literal_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [34:32] status, [39:35] zero
	output logic [1:0]  m_tuser    // [1:0] kind
);
	import intlex_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       step;
	logic       out_valid_q;
	token_t     token;
	token_t     token_q;

	assign step     = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	intlex_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.is_last   (last_s1),
		.token     (token)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && last_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1)
			token_q <= token;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, token_q.status, token_q.value};
	assign m_tuser  = token_q.kind;

endmodule

[dv/integer_literal_lexer_tb.sv]
module integer_literal_lexer_tb;
	import intlex_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 12;
	localparam int RANDOM_BEATS = 1650;
	// window where both sides run flat out
	localparam int CALM_LO = 1200;
	localparam int CALM_HI = 1700;
	// one long sink hold-off so the lexer backs up
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	integer_literal_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// {last, char} beats waiting for the driver
	logic [8:0] char_beats[$];
	logic [7:0] lit_buf[$];
	logic [8:0] next_beat;
	token_t     pending_tokens[$];

	int cycle = 0;
	int hold_cnt = 0;
	int total_beats = 0;
	int beats_taken = 0;
	int literal_cnt = 0;
	int tokens_checked = 0;
	int fail_cnt = 0;
	int status_seen[5];

	// lexer shadow state
	logic       first_pos;
	logic [1:0] sign_kind;
	logic [7:0] lead_char;
	logic [3:0] sig_digits;
	logic [1:0] base_guess;
	logic [2:0] err_code;
	logic [31:0] oct_acc;
	logic [31:0] hex_acc;
	logic [31:0] dec_acc;
	logic       dec_overflow;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [7:0] hex_char(int n, bit upper);
		if (n < 10) return CH_ZERO + 8'(n);
		return (upper ? CH_UP_A : CH_LO_A) + 8'(n - 10);
	endfunction

	task automatic clear_lexer();
		first_pos = 1'b1;
		sign_kind = SIGN_NONE;
		lead_char = '0;
		sig_digits = '0;
		base_guess = KIND_OCT;
		err_code = ST_OK;
		oct_acc = '0;
		hex_acc = '0;
		dec_acc = '0;
		dec_overflow = 1'b0;
	endtask

	task automatic flag(logic [2:0] e);
		if (err_code == ST_OK) err_code = e;
	endtask

	task automatic add_digit(logic [7:0] c);
		logic [63:0] prod;
		if (lead_char == 8'd0) lead_char = c;
		if (sig_digits < CNT_SAT) sig_digits++;
		hex_acc = {hex_acc[27:0], 4'(nibble_of(c))};
		if (is_digit(c)) begin
			oct_acc = {oct_acc[28:0], 3'b000} + 32'(c - CH_ZERO);
			if (!dec_overflow) begin
				prod = {32'd0, dec_acc} * 64'd10 + {56'd0, c - CH_ZERO};
				if (prod > 64'(DEC_LIMIT)) dec_overflow = 1'b1;
				else dec_acc = prod[31:0];
			end
		end
	endtask

	task automatic close_token();
		token_t tok;
		logic [31:0] v;
		v = '0;
		if (err_code == ST_OK && sign_kind != SIGN_NONE && base_guess != KIND_DEC)
			flag(ST_SIGN);
		if (err_code == ST_OK) begin
			case (base_guess)
				KIND_OCT: begin
					if (sig_digits > OCT_MAX_DIGITS ||
							(sig_digits == OCT_MAX_DIGITS && lead_char > CH_THREE))
						flag(ST_OVERFLOW);
					v = oct_acc;
				end
				KIND_HEX: begin
					if (sig_digits > HEX_MAX_DIGITS) flag(ST_OVERFLOW);
					v = hex_acc;
				end
				default: begin
					if (dec_overflow || sig_digits > DEC_MAX_DIGITS) flag(ST_OVERFLOW);
					v = (sign_kind == SIGN_MINUS) ? -dec_acc : dec_acc;
				end
			endcase
		end
		tok.kind = (err_code == ST_OK || err_code == ST_SIGN || err_code == ST_OVERFLOW) ?
			base_guess : KIND_OCT;
		tok.value = (err_code == ST_OK) ? v : '0;
		tok.status = err_code;
		pending_tokens.push_back(tok);
		clear_lexer();
	endtask

	task automatic lex_char(logic [7:0] c, logic last);
		if (first_pos && (c == CH_PLUS || c == CH_MINUS)) begin
			first_pos = 1'b0;
			sign_kind = (c == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
			if (last) begin
				// a sign alone is a bad suffix
				flag(ST_BAD_SUFFIX);
				close_token();
			end
		end else if (!last) begin
			first_pos = 1'b0;
			if (err_code == ST_OK) begin
				if (c == CH_ZERO && sig_digits == 0) begin
					// leading zero, not significant
				end else if (nibble_of(c) >= 0) begin
					add_digit(c);
					if (!is_digit(c)) base_guess = KIND_HEX;
					else if (c >= CH_NINE - 8'd1 && base_guess == KIND_OCT)
						base_guess = KIND_DEC;
				end else begin
					flag(ST_INVALID);
				end
			end
		end else begin
			if (err_code == ST_OK) begin
				if (c == CH_LO_H || c == CH_UP_H) begin
					base_guess = KIND_HEX;
				end else if (c == CH_LO_B || c == CH_UP_B) begin
					if (base_guess != KIND_OCT) flag(ST_BAD_SUFFIX);
				end else if (is_digit(c)) begin
					if (base_guess == KIND_HEX) begin
						flag(ST_BAD_SUFFIX);
					end else begin
						base_guess = KIND_DEC;
						if (!(c == CH_ZERO && sig_digits == 0)) add_digit(c);
					end
				end else begin
					flag(ST_BAD_SUFFIX);
				end
			end
			close_token();
		end
	endtask

	task automatic commit_literal();
		foreach (lit_buf[i]) char_beats.push_back({i == lit_buf.size() - 1, lit_buf[i]});
		lit_buf.delete();
		literal_cnt++;
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
		commit_literal();
	endtask

	task automatic push_sign(int one_in);
		if ($urandom_range(0, one_in - 1) == 0)
			lit_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
	endtask

	task automatic push_zeros();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) lit_buf.push_back(CH_ZERO);
	endtask

	task automatic gen_literal();
		int style;
		int n;
		int pos;
		longint v;
		string s;
		style = $urandom_range(0, 99);
		if (style < 27) begin
			push_sign(3);
			push_zeros();
			case ($urandom_range(0, 4))
				0: v = $urandom_range(0, 99);
				1: v = $urandom;
				2: v = 64'd2147483646 + $urandom_range(0, 2);
				3: v = $urandom_range(0, 2147483647);
				default: v = longint'($urandom) * $urandom_range(3, 300);
			endcase
			s = $sformatf("%0d", v);
			for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
		end else if (style < 54) begin
			push_sign(8);
			push_zeros();
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 9);
			for (int i = 0; i < n; i++) begin
				if (i == 0)
					lit_buf.push_back(CH_ZERO + 8'(n == 11 ? $urandom_range(2, 5) :
						$urandom_range(1, 7)));
				else
					lit_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			lit_buf.push_back($urandom_range(0, 1) ? CH_UP_B : CH_LO_B);
		end else if (style < 81) begin
			push_sign(8);
			push_zeros();
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				lit_buf.push_back(hex_char($urandom_range(i == 0 ? 1 : 0, 15), $urandom_range(0, 1)));
			lit_buf.push_back($urandom_range(0, 1) ? CH_UP_H : CH_LO_H);
		end else if (style < 91) begin
			// hex-looking body, random suffix, one char possibly corrupted
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				lit_buf.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
			case ($urandom_range(0, 2))
				0: lit_buf.push_back(CH_LO_H);
				1: lit_buf.push_back(CH_LO_B);
				default: lit_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			endcase
			if ($urandom_range(0, 1)) begin
				pos = $urandom_range(0, lit_buf.size() - 1);
				lit_buf[pos] = 8'($urandom_range(0, 255));
			end
		end else begin
			n = $urandom_range(1, 5);
			repeat (n) lit_buf.push_back(8'($urandom_range(0, 255)));
		end
		commit_literal();
	endtask

	function automatic bit calm();
		return cycle >= CALM_LO && cycle < CALM_HI;
	endfunction

	// character driver; the shadow lexer follows every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				lex_char(s_tdata, s_tlast);
				beats_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (char_beats.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_beat = char_beats.pop_front();
					s_tdata <= next_beat[7:0];
					s_tlast <= next_beat[8];
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// token sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
		end else if (cycle == HOLD_AT) begin
			m_tready <= 1'b0;
			hold_cnt <= HOLD_LEN;
		end else if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			m_tready <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// token checker
	always @(posedge clk) begin
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				$error("token with no literal pending: value %0d status %0d kind %0d",
					$signed(m_tdata[31:0]), m_tdata[34:32], m_tuser);
				fail_cnt++;
			end else begin
				want = pending_tokens.pop_front();
				tokens_checked++;
				if (m_tdata[31:0] !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value),
						$signed(m_tdata[31:0]));
					fail_cnt++;
				end
				if (m_tdata[34:32] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[34:32]);
					fail_cnt++;
				end
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					fail_cnt++;
				end
				if (want.status <= ST_OVERFLOW) status_seen[want.status]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		clear_lexer();
		foreach (status_seen[i]) status_seen[i] = 0;
		queue_text("+");
		queue_text("0");
		queue_text("-00");
		queue_text("h");
		queue_text("b");
		queue_text("7b");
		queue_text("fH");
		queue_text("a9");
		queue_text("8b");
		queue_text("1-2");
		queue_text("+7b");
		queue_text("x");
		queue_text("9");
		n_loop: while (char_beats.size() < RANDOM_BEATS + 25) gen_literal();
		total_beats = char_beats.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (beats_taken < total_beats) @(posedge clk);
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d literals over %0d character beats, %0d tokens compared",
			literal_cnt, total_beats, tokens_checked);
		$display("ok %0d, invalid char %0d, bad suffix %0d, sign %0d, overflow %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
